[rtl/edd_pkg.sv]
// Shared constants, register codes and the per-pixel error add for the
// error diffusion dither. No dependencies.
package edd_pkg;

  localparam int GRAY_W             = 8;
  localparam int COLUMN_LENGTH_W    = 11;
  localparam int COLUMN_COUNT_W     = 13;
  localparam int COLUMN_INDEX_W     = 12;
  localparam int MAX_COLUMN_LENGTH  = 1024;
  localparam int MAX_COLUMN_COUNT   = 4096;
  localparam int RIGHT_ERR_W        = 10;
  localparam int DIAG_ERR_W         = 9;
  localparam int APB_ADDR_W         = 3;
  localparam int APB_DATA_W         = 32;

  localparam logic [GRAY_W-1:0] BLACK_LIMIT = 8'd127;
  localparam logic [GRAY_W-1:0] FULL_WHITE  = 8'd255;

  localparam logic [COLUMN_LENGTH_W-1:0] COLUMN_LENGTH_RST = 11'd1024;
  localparam logic [COLUMN_COUNT_W-1:0]  COLUMN_COUNT_RST  = 13'd1024;

  typedef enum logic {
    REG_COLUMN_LENGTH = 1'b0,
    REG_COLUMN_COUNT  = 1'b1
  } reg_index_t;

  // One stored error word per row: 3e for the right neighbor, 2e for the diagonal.
  typedef struct packed {
    logic signed [RIGHT_ERR_W-1:0] right;
    logic signed [DIAG_ERR_W-1:0]  diag;
  } err_word_t;

  // value + eighths/8, rounded half up, clamped to 0..255
  function automatic logic [GRAY_W-1:0] add_eighths(input logic [GRAY_W-1:0] value,
                                                     input logic signed [RIGHT_ERR_W-1:0] eighths);
    logic signed [12:0] t;
    logic [GRAY_W-1:0]  r;
    t = $signed({2'b00, value, 3'b000}) + 13'(eighths) + 13'sd4;
    if (t < 13'sd0) begin
      r = '0;
    end else if (t[11:3] > 9'(FULL_WHITE)) begin
      r = FULL_WHITE;
    end else begin
      r = t[10:3];
    end
    return r;
  endfunction

endpackage

[rtl/edd_if.sv]
// Valid/ready stream interfaces for gray pixels in and dither bits out.
// Depends on edd_pkg.
interface edd_gray_if;
  import edd_pkg::*;
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray;

  modport source (output valid, output gray, input ready);
  modport sink   (input valid, input gray, output ready);
endinterface

interface edd_bit_if;
  logic valid;
  logic ready;
  logic white;
  logic end_of_image;

  modport source (output valid, output white, output end_of_image, input ready);
  modport sink   (input valid, input white, input end_of_image, output ready);
endinterface

[rtl/error_diffusion_dither.sv]
// Error diffusion dither, column-major scan, with APB-style register port.
// Depends on edd_pkg and the stream interfaces in edd_if.sv.
//
//   channel  | dir | beat payload              | handshake
//   ---------+-----+---------------------------+-------------
//   pixel    | in  | gray[7:0]                 | valid/ready
//   result   | out | white, end_of_image       | valid/ready
//   apb      | in  | column_length, column_cnt | psel/penable
//
// One pixel per cycle sustained unless result stalls. Accepting loads the input stage
// and reads the row error memory; advancing loads the result register (add/clamp chain).
// The diag/right/down add-clamp chain is the only logic between the two registers.
// rst clears position, pending errors and valids; the error memory needs no clearing.
// A stalled result holds its beat; one more pixel waits in the input stage.
module error_diffusion_dither #(
  parameter int MAX_COLUMN_LENGTH = edd_pkg::MAX_COLUMN_LENGTH
) (
  input  logic                          clk,
  input  logic                          rst,
  edd_gray_if.sink                      pixel,
  edd_bit_if.source                     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [edd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [edd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [edd_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import edd_pkg::*;

  localparam int AW = $clog2(MAX_COLUMN_LENGTH);

  // configuration
  logic [COLUMN_LENGTH_W-1:0] column_length;
  logic [COLUMN_COUNT_W-1:0]  column_count;
  logic                       cfg_wr;
  reg_index_t                 cfg_idx;
  logic [12:0]                eff_len;
  logic [12:0]                eff_cnt;
  logic [12:0]                len_m1_w;
  logic [12:0]                cnt_m1_w;
  logic [AW-1:0]              len_m1;
  logic [COLUMN_INDEX_W-1:0]  cnt_m1;

  // position
  logic [AW-1:0]              row;
  logic [COLUMN_INDEX_W-1:0]  col;
  logic [AW-1:0]              row_next;
  logic [COLUMN_INDEX_W-1:0]  col_next;

  // input stage
  logic                       s1_valid;
  logic [GRAY_W-1:0]          s1_gray;
  logic [AW-1:0]              s1_row;
  logic                       s1_first_row;
  logic                       s1_first_col;
  logic                       s1_last;
  logic                       fwd;
  err_word_t                  fwd_word;
  err_word_t                  rd_word;
  err_word_t                  mem [MAX_COLUMN_LENGTH];

  // pending errors
  logic signed [RIGHT_ERR_W-1:0] down_error;
  logic signed [DIAG_ERR_W-1:0]  diag_carry;

  // compute
  logic                       accept;
  logic                       advance;
  err_word_t                  cur_word;
  err_word_t                  wr_word;
  logic [GRAY_W-1:0]          v1;
  logic [GRAY_W-1:0]          v2;
  logic [GRAY_W-1:0]          v3;
  logic                       is_white;
  logic signed [8:0]          err;

  // ---------------- register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_index_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_COLUMN_LENGTH: prdata = APB_DATA_W'(column_length);
      REG_COLUMN_COUNT:  prdata = APB_DATA_W'(column_count);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_length <= COLUMN_LENGTH_RST;
      column_count  <= COLUMN_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COLUMN_LENGTH: column_length <= pwdata[COLUMN_LENGTH_W-1:0];
        REG_COLUMN_COUNT:  column_count  <= pwdata[COLUMN_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (column_length == '0) begin
      eff_len = 13'd1;
    end else if (13'(column_length) > 13'(MAX_COLUMN_LENGTH)) begin
      eff_len = 13'(MAX_COLUMN_LENGTH);
    end else begin
      eff_len = 13'(column_length);
    end
    if (column_count == '0) begin
      eff_cnt = 13'd1;
    end else if (column_count > 13'(MAX_COLUMN_COUNT)) begin
      eff_cnt = 13'(MAX_COLUMN_COUNT);
    end else begin
      eff_cnt = column_count;
    end
    len_m1_w = eff_len - 13'd1;
    cnt_m1_w = eff_cnt - 13'd1;
  end

  assign len_m1 = len_m1_w[AW-1:0];
  assign cnt_m1 = cnt_m1_w[COLUMN_INDEX_W-1:0];

  // ---------------- handshake
  assign advance      = s1_valid && (!result.valid || result.ready);
  assign accept       = pixel.valid && pixel.ready;
  assign pixel.ready  = !s1_valid || advance;

  // ---------------- position counters
  always_comb begin
    if (row == len_m1) begin
      row_next = '0;
      col_next = (col == cnt_m1) ? '0 : col + 1'b1;
    end else begin
      row_next = row + 1'b1;
      col_next = col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

  // ---------------- input stage and error memory
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gray      <= pixel.gray;
      s1_row       <= row;
      s1_first_row <= (row == '0);
      s1_first_col <= (col == '0);
      s1_last      <= (row == len_m1) && (col == cnt_m1);
      // one-row columns read the row being written in the same cycle
      fwd          <= advance && (s1_row == row);
      fwd_word     <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= mem[row];
    end
    if (advance) begin
      mem[s1_row] <= wr_word;
    end
  end

  // ---------------- add/clamp chain: diagonal, right, down
  always_comb begin
    cur_word = fwd ? fwd_word : rd_word;
    v1 = (!s1_first_col && !s1_first_row) ?
         add_eighths(s1_gray, RIGHT_ERR_W'(diag_carry)) : s1_gray;
    v2 = !s1_first_col ? add_eighths(v1, cur_word.right) : v1;
    v3 = !s1_first_row ? add_eighths(v2, down_error) : v2;
    is_white = v3 > BLACK_LIMIT;
    err = is_white ? $signed({1'b0, v3}) - $signed({1'b0, FULL_WHITE}) : $signed({1'b0, v3});
    wr_word.right = RIGHT_ERR_W'(err) + (RIGHT_ERR_W'(err) <<< 1);
    wr_word.diag  = $signed({err[7:0], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      down_error <= '0;
      diag_carry <= '0;
    end else if (advance) begin
      down_error <= wr_word.right;
      diag_carry <= s1_first_col ? '0 : cur_word.diag;
    end
  end

  // ---------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.white        <= is_white;
      result.end_of_image <= s1_last;
    end
  end

  // ---------------- assertions
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> result.valid)
    else $error("computed pixel did not reach result register");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && result.valid && !result.ready |=> s1_valid)
    else $error("input stage lost a pixel under stall");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row <= len_m1)
    else $error("row counter beyond column length");

  a_fwd_one_row: assert property (@(posedge clk) disable iff (rst)
    s1_valid && fwd |-> len_m1 == '0)
    else $error("error forwarding outside one-row columns");

endmodule
